// File: design/bitmap_bit_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// bitmap bit allocator assertion macros
// clocked property checks used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef BITMAP_BIT_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_BIT_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define BBA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared types, request codes and sizes of the bitmap bit allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int WORD_COUNT_DEF = 1024;
    localparam int WORD_BITS_DEF  = 32;

    localparam int REQ_W      = 3;
    localparam int START_W    = 10;
    localparam int BIT_W      = 15;
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 16;
    localparam int POS_W      = 6;
    localparam int BYTE_IDX_W = 17;

    localparam logic [CFG_W-1:0] BITS_IN_USE_RST = 16'd32768;

    localparam logic [REQ_W-1:0] REQ_ALLOC_BIT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC_BYTE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FREE_BIT   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WRITE_WORD = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ_WORD  = 3'd4;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [START_W-1:0] start_word;
        logic [BIT_W-1:0]   bit_index;
        logic [DATA_W-1:0]  word_value;
    } t_req_item;

    typedef struct packed {
        logic              status;
        logic [BIT_W-1:0]  bit_number;
        logic [DATA_W-1:0] word_data;
    } t_rsp_item;

    typedef enum logic {
        SCAN_BIT,
        SCAN_BYTE
    } t_scan_mode;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
    } t_scan_hit;

endpackage

`default_nettype wire

// File: design/bba_bitmap_ram.sv
// ----------------------------------------------------------------------------
// bba_bitmap_ram
// bitmap word store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bba_bitmap_ram #(
    parameter  int WORD_COUNT = bba_pkg::WORD_COUNT_DEF,
    parameter  int WORD_BITS  = bba_pkg::WORD_BITS_DEF,
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WORD_BITS-1:0] i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [WORD_COUNT];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/bba_scan_unit.sv
// ----------------------------------------------------------------------------
// bba_scan_unit
// shared word search: lowest clear bit, or lowest free byte below the byte
// limit, and the word with that bit or byte set
// ----------------------------------------------------------------------------
`default_nettype none

module bba_scan_unit #(
    parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF
) (
    input  bba_pkg::t_scan_mode               i_mode,
    input  logic [WORD_BITS-1:0]              i_word,
    input  logic [bba_pkg::BYTE_IDX_W-1:0]    i_byte_base,
    input  logic [bba_pkg::BYTE_IDX_W-1:0]    i_byte_lim,
    output bba_pkg::t_scan_hit                o_hit,
    output logic [WORD_BITS-1:0]              o_set_word
);

    localparam int BPW = WORD_BITS / 8;

    always_comb begin
        o_hit      = '0;
        o_set_word = i_word;
        if (i_mode == bba_pkg::SCAN_BIT) begin
            for (int i = WORD_BITS - 1; i >= 0; i--) begin
                if (!i_word[i]) begin
                    o_hit.hit = 1'b1;
                    o_hit.pos = bba_pkg::POS_W'(i);
                end
            end
            o_set_word = i_word | (WORD_BITS'(1) << o_hit.pos);
        end else begin
            for (int k = BPW - 1; k >= 0; k--) begin
                if ((i_word[k*8 +: 8] == 8'h00) &&
                    ((i_byte_base + bba_pkg::BYTE_IDX_W'(k)) < i_byte_lim)) begin
                    o_hit.hit = 1'b1;
                    o_hit.pos = bba_pkg::POS_W'(k);
                end
            end
            o_set_word = i_word | (WORD_BITS'(8'hFF) << {o_hit.pos, 3'b000});
        end
    end

endmodule

`default_nettype wire

// File: design/bitmap_bit_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_bit_allocator_top
// First-fit allocator over a bitmap of WORD_COUNT words of WORD_BITS bits.
// One item is worked on at a time. Allocate-bit and allocate-byte read one
// bitmap word per cycle through a single read port and test it in one shared
// search unit, then register their result. Free-bit and read-word go
// through read, check and result steps; write-word writes the word, if in
// range, when it is taken and then gives its result. A finished result waits
// in the output register while the next item is taken. After reset the store
// is cleared one word per cycle, and no item is taken until that ends;
// bits_in_use may be written at any time the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitmap_bit_allocator_top_defines.svh"

module bitmap_bit_allocator_top #(
    parameter int WORD_COUNT = bba_pkg::WORD_COUNT_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bba_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bba_pkg::t_req_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bba_pkg::t_rsp_item            o_out_item
);

    localparam int AW       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int CNT_W    = $clog2(WORD_COUNT + 1);
    localparam int PTR_W    = (CNT_W > bba_pkg::START_W) ? CNT_W : bba_pkg::START_W;
    localparam int BP_W     = $clog2(WORD_BITS);
    localparam int BPW      = WORD_BITS / 8;
    localparam int BYTE_CAP = WORD_COUNT * BPW;
    localparam int WIDE_W   = 24;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_READ,
        S_DONE
    } t_state;

    t_state                            r_state, n_state;
    logic [bba_pkg::CFG_W-1:0]         r_bits_in_use, n_bits_in_use;
    logic [AW-1:0]                     r_clr_addr, n_clr_addr;
    bba_pkg::t_scan_mode               r_mode, n_mode;
    logic [PTR_W-1:0]                  r_ptr, n_ptr;
    logic [PTR_W-1:0]                  r_lim, n_lim;
    logic [bba_pkg::BYTE_IDX_W-1:0]    r_lim8, n_lim8;
    logic                              r_chk_valid, n_chk_valid;
    logic [AW-1:0]                     r_chk_addr, n_chk_addr;
    logic [AW-1:0]                     r_waddr, n_waddr;
    logic                              r_oob, n_oob;
    logic [BP_W-1:0]                   r_bitpos, n_bitpos;
    bba_pkg::t_rsp_item                r_res, n_res;
    logic                              r_out_valid, n_out_valid;
    bba_pkg::t_rsp_item                r_out_item, n_out_item;

    logic                              accept;
    logic [bba_pkg::BIT_W-1:0]         free_w;
    logic                              free_oob;
    logic [BP_W-1:0]                   free_pos;
    logic                              sw_oob;
    logic [bba_pkg::CFG_W-1:0]         lim_words_raw;
    logic [PTR_W-1:0]                  lim_bit_w;
    logic [bba_pkg::CFG_W-1:0]         lim8_raw;
    logic [bba_pkg::BYTE_IDX_W-1:0]    lim8;
    logic [PTR_W-1:0]                  lim_byte_w;

    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic [WORD_BITS-1:0]              mem_wdata;
    logic [AW-1:0]                     mem_raddr;
    logic [WORD_BITS-1:0]              mem_rdata;

    logic [bba_pkg::BYTE_IDX_W-1:0]    byte_base;
    bba_pkg::t_scan_hit                scan_hit;
    logic [WORD_BITS-1:0]              set_word;
    logic [bba_pkg::BYTE_IDX_W-1:0]    byte_j;
    logic [WIDE_W-1:0]                 bit_num_wide;
    logic [WIDE_W-1:0]                 byte_bit_wide;
    logic                              issue;
    logic                              take;
    logic                              refuse;
    logic [bba_pkg::BIT_W-1:0]         take_bitnum;

    bba_bitmap_ram #(
        .WORD_COUNT (WORD_COUNT),
        .WORD_BITS  (WORD_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bba_scan_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_scan (
        .i_mode      (r_mode),
        .i_word      (mem_rdata),
        .i_byte_base (byte_base),
        .i_byte_lim  (r_lim8),
        .o_hit       (scan_hit),
        .o_set_word  (set_word)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // request decode and scan limits
    always_comb begin
        free_w        = bba_pkg::BIT_W'(i_in_item.bit_index / WORD_BITS);
        free_oob      = (32'(free_w) >= WORD_COUNT);
        free_pos      = BP_W'(i_in_item.bit_index % WORD_BITS);
        sw_oob        = (32'(i_in_item.start_word) >= WORD_COUNT);
        lim_words_raw = bba_pkg::CFG_W'(r_bits_in_use / WORD_BITS);
        lim_bit_w     = (32'(lim_words_raw) > WORD_COUNT) ? PTR_W'(WORD_COUNT)
                                                          : PTR_W'(lim_words_raw);
        lim8_raw      = r_bits_in_use >> 3;
        lim8          = (32'(lim8_raw) > BYTE_CAP) ? bba_pkg::BYTE_IDX_W'(BYTE_CAP)
                                                   : bba_pkg::BYTE_IDX_W'(lim8_raw);
        lim_byte_w    = PTR_W'((32'(lim8) + BPW - 1) / BPW);
    end

    // scan word check
    always_comb begin
        byte_base     = bba_pkg::BYTE_IDX_W'(32'(r_chk_addr) * BPW);
        byte_j        = byte_base + bba_pkg::BYTE_IDX_W'(scan_hit.pos);
        bit_num_wide  = WIDE_W'(r_chk_addr) * WIDE_W'(WORD_BITS) + WIDE_W'(scan_hit.pos);
        byte_bit_wide = WIDE_W'({byte_j, 3'b000});
        issue         = (r_ptr < r_lim);
        if (r_mode == bba_pkg::SCAN_BIT) begin
            take        = scan_hit.hit && (bit_num_wide < WIDE_W'(r_bits_in_use));
            refuse      = 1'b0;
            take_bitnum = bba_pkg::BIT_W'(bit_num_wide);
        end else begin
            take        = scan_hit.hit &&
                          ((byte_bit_wide + WIDE_W'(8)) < WIDE_W'(r_bits_in_use));
            refuse      = scan_hit.hit && !take;
            take_bitnum = bba_pkg::BIT_W'(byte_bit_wide);
        end
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_bits_in_use = r_bits_in_use;
        n_clr_addr    = r_clr_addr;
        n_mode        = r_mode;
        n_ptr         = r_ptr;
        n_lim         = r_lim;
        n_lim8        = r_lim8;
        n_chk_valid   = r_chk_valid;
        n_chk_addr    = r_chk_addr;
        n_waddr       = r_waddr;
        n_oob         = r_oob;
        n_bitpos      = r_bitpos;
        n_res         = r_res;
        n_out_valid   = r_out_valid;
        n_out_item    = r_out_item;
        mem_we        = 1'b0;
        mem_waddr     = r_chk_addr;
        mem_wdata     = set_word;
        mem_raddr     = r_ptr[AW-1:0];

        if (i_cfg_we) begin
            n_bits_in_use = i_cfg_data;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(WORD_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                mem_raddr = (i_in_item.req_type == bba_pkg::REQ_FREE_BIT) ?
                            AW'(free_w) : AW'(i_in_item.start_word);
                if (accept) begin
                    n_res       = '0;
                    n_chk_valid = 1'b0;
                    case (i_in_item.req_type)
                        bba_pkg::REQ_ALLOC_BIT: begin
                            n_mode  = bba_pkg::SCAN_BIT;
                            n_ptr   = PTR_W'(i_in_item.start_word);
                            n_lim   = lim_bit_w;
                            n_state = S_SCAN;
                        end
                        bba_pkg::REQ_ALLOC_BYTE: begin
                            n_mode  = bba_pkg::SCAN_BYTE;
                            n_ptr   = '0;
                            n_lim   = lim_byte_w;
                            n_lim8  = lim8;
                            n_state = S_SCAN;
                        end
                        bba_pkg::REQ_FREE_BIT: begin
                            n_waddr  = AW'(free_w);
                            n_oob    = free_oob;
                            n_bitpos = free_pos;
                            n_state  = S_FREE;
                        end
                        bba_pkg::REQ_WRITE_WORD: begin
                            mem_we       = !sw_oob;
                            mem_waddr    = AW'(i_in_item.start_word);
                            mem_wdata    = WORD_BITS'(i_in_item.word_value);
                            n_res.status = bba_pkg::ST_OK;
                            n_state      = S_DONE;
                        end
                        bba_pkg::REQ_READ_WORD: begin
                            n_oob   = sw_oob;
                            n_state = S_READ;
                        end
                        default: begin
                            n_res.status = bba_pkg::ST_FAIL;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_chk_valid && take) begin
                    mem_we           = 1'b1;
                    mem_waddr        = r_chk_addr;
                    mem_wdata        = set_word;
                    n_res.status     = bba_pkg::ST_OK;
                    n_res.bit_number = take_bitnum;
                    n_chk_valid      = 1'b0;
                    n_state          = S_DONE;
                end else if (r_chk_valid && refuse) begin
                    n_res.status = bba_pkg::ST_FAIL;
                    n_chk_valid  = 1'b0;
                    n_state      = S_DONE;
                end else if (issue) begin
                    n_ptr       = r_ptr + 1'b1;
                    n_chk_valid = 1'b1;
                    n_chk_addr  = r_ptr[AW-1:0];
                end else if (!r_chk_valid) begin
                    n_res.status = bba_pkg::ST_FAIL;
                    n_state      = S_DONE;
                end else begin
                    n_chk_valid = 1'b0;
                end
            end
            S_FREE: begin
                if (r_oob || !mem_rdata[r_bitpos]) begin
                    n_res.status = bba_pkg::ST_FAIL;
                end else begin
                    mem_we       = 1'b1;
                    mem_waddr    = r_waddr;
                    mem_wdata    = mem_rdata & ~(WORD_BITS'(1) << r_bitpos);
                    n_res.status = bba_pkg::ST_OK;
                end
                n_state = S_DONE;
            end
            S_READ: begin
                if (r_oob) begin
                    n_res.status = bba_pkg::ST_FAIL;
                end else begin
                    n_res.status    = bba_pkg::ST_OK;
                    n_res.word_data = bba_pkg::DATA_W'(mem_rdata);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_item  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_bits_in_use <= bba_pkg::BITS_IN_USE_RST;
            r_clr_addr    <= '0;
            r_chk_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_bits_in_use <= n_bits_in_use;
            r_clr_addr    <= n_clr_addr;
            r_chk_valid   <= n_chk_valid;
            r_out_valid   <= n_out_valid;
        end
        r_mode     <= n_mode;
        r_ptr      <= n_ptr;
        r_lim      <= n_lim;
        r_lim8     <= n_lim8;
        r_chk_addr <= n_chk_addr;
        r_waddr    <= n_waddr;
        r_oob      <= n_oob;
        r_bitpos   <= n_bitpos;
        r_res      <= n_res;
        r_out_item <= n_out_item;
    end

    `BBA_ASSERT_NEXT(a_accept_drops_ready, i_in_valid && o_in_ready, !o_in_ready, "ready high after accept")
    `BBA_ASSERT_NEXT(a_done_loads_out, (r_state == S_DONE) && (!r_out_valid || i_out_ready), r_out_valid && (r_state == S_IDLE), "result not loaded")
    `BBA_ASSERT_SAME(a_check_only_in_scan, r_chk_valid, r_state == S_SCAN, "word check outside scan")

endmodule

`default_nettype wire

// File: bench/bitmap_bit_allocator_top_test.sv
// ----------------------------------------------------------------------------
// bitmap_bit_allocator_top_test
// Drives requests into the bitmap allocator and predicts each response from
// a private copy of the bitmap and of bits_in_use. Directed requests cover
// the field extremes, every request type and the scan limit cases, then
// random traffic runs under several bits_in_use settings, most phases with
// random gaps and output stalls. Every response is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_bit_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    localparam int MAP_WORDS      = WORD_COUNT_DEF;
    localparam int MAP_WORD_BITS  = WORD_BITS_DEF;
    localparam int BYTES_IN_WORD  = MAP_WORD_BITS / 8;
    localparam int STUCK_LIMIT    = 20000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_REQS     = 205;
    localparam int RANDOM_PHASES  = 8;
    localparam logic [REQ_W-1:0] REQ_CODE_MAX = '1;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    t_req_item         in_item   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_rsp_item         out_item;

    logic [MAP_WORD_BITS-1:0] map_words [MAP_WORDS];
    logic [CFG_W-1:0]         map_bits = BITS_IN_USE_RST;
    t_rsp_item                rsp_due [$];
    int                       fail_count = 0;
    int                       stuck_cycles = 0;
    bit                       no_gaps = 1'b0;

    bitmap_bit_allocator_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always #4 clk = ~clk;

    initial begin
        for (int w = 0; w < MAP_WORDS; w++) begin
            map_words[w] = '0;
        end
    end

    function automatic t_rsp_item compute_rsp(input t_req_item rq);
        t_rsp_item   rs;
        int unsigned lim;
        int unsigned w;
        int unsigned j;
        int unsigned i;
        int unsigned b;
        int unsigned sh;
        bit          done;
        rs = '0;
        rs.status = ST_FAIL;
        done = 1'b0;
        case (rq.req_type)
            REQ_ALLOC_BIT: begin
                lim = map_bits / MAP_WORD_BITS;
                if (lim > MAP_WORDS) lim = MAP_WORDS;
                for (w = rq.start_word; w < lim && !done; w++) begin
                    if (map_words[w] != '1) begin
                        i = 0;
                        while (i < MAP_WORD_BITS - 1 && map_words[w][i]) i++;
                        b = w * MAP_WORD_BITS + i;
                        if (b < map_bits) begin
                            map_words[w][i] = 1'b1;
                            rs.status = ST_OK;
                            rs.bit_number = b[BIT_W-1:0];
                            done = 1'b1;
                        end
                    end
                end
            end
            REQ_ALLOC_BYTE: begin
                lim = map_bits / 8;
                if (lim > MAP_WORDS * BYTES_IN_WORD) lim = MAP_WORDS * BYTES_IN_WORD;
                for (j = 0; j < lim && !done; j++) begin
                    w = j / BYTES_IN_WORD;
                    sh = (j % BYTES_IN_WORD) * 8;
                    if (map_words[w][sh +: 8] == 8'h00 && j * 8 + 8 < map_bits) begin
                        map_words[w][sh +: 8] = 8'hFF;
                        rs.status = ST_OK;
                        rs.bit_number = BIT_W'(j * 8);
                        done = 1'b1;
                    end
                end
            end
            REQ_FREE_BIT: begin
                w = rq.bit_index / MAP_WORD_BITS;
                i = rq.bit_index % MAP_WORD_BITS;
                if (w < MAP_WORDS && map_words[w][i]) begin
                    map_words[w][i] = 1'b0;
                    rs.status = ST_OK;
                end
            end
            REQ_WRITE_WORD: begin
                if (rq.start_word < MAP_WORDS) map_words[rq.start_word] = rq.word_value;
                rs.status = ST_OK;
            end
            REQ_READ_WORD: begin
                if (rq.start_word < MAP_WORDS) begin
                    rs.status = ST_OK;
                    rs.word_data = map_words[rq.start_word][DATA_W-1:0];
                end
            end
            default: begin
                rs.status = ST_FAIL;
            end
        endcase
        return rs;
    endfunction

    function automatic t_req_item make_req(input logic [REQ_W-1:0] kind,
                                           input int unsigned sw,
                                           input int unsigned bi,
                                           input logic [DATA_W-1:0] wv);
        t_req_item rq;
        rq.req_type   = kind;
        rq.start_word = START_W'(sw);
        rq.bit_index  = BIT_W'(bi);
        rq.word_value = wv;
        return rq;
    endfunction

    function automatic t_req_item random_req();
        t_req_item   rq;
        int unsigned pick;
        int unsigned lim_w;
        int unsigned top_bit;
        rq.start_word = START_W'($urandom);
        rq.bit_index  = BIT_W'($urandom);
        rq.word_value = $urandom;
        lim_w = map_bits / MAP_WORD_BITS;
        if (lim_w > MAP_WORDS - 1) lim_w = MAP_WORDS - 1;
        top_bit = (map_bits == 0) ? 0 : map_bits - 1;
        if (top_bit > 2 ** BIT_W - 1) top_bit = 2 ** BIT_W - 1;
        if ($urandom_range(0, 99) < 80) rq.start_word = START_W'($urandom_range(0, lim_w));
        if ($urandom_range(0, 99) < 75) rq.bit_index = BIT_W'($urandom_range(0, top_bit));
        case ($urandom_range(0, 3))
            0: rq.word_value = '0;
            1: rq.word_value = '1;
            2: rq.word_value = $urandom & $urandom & $urandom;
            default: ;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 30) rq.req_type = REQ_ALLOC_BIT;
        else if (pick < 42) rq.req_type = REQ_ALLOC_BYTE;
        else if (pick < 67) rq.req_type = REQ_FREE_BIT;
        else if (pick < 79) rq.req_type = REQ_WRITE_WORD;
        else if (pick < 94) rq.req_type = REQ_READ_WORD;
        else rq.req_type = REQ_W'($urandom_range(REQ_READ_WORD + 1, REQ_CODE_MAX));
        return rq;
    endfunction

    task automatic send_req(input t_req_item rq);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= rq;
        do @(posedge clk); while (!in_ready);
        rsp_due.push_back(compute_rsp(rq));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (rsp_due.size() != 0) @(posedge clk);
    endtask

    task automatic set_map_bits(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        map_bits = value;
    endtask

    initial begin
        int stall;
        t_rsp_item exp_rsp;
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && rst_n));
            if (rsp_due.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h", $realtime, out_item);
                fail_count++;
            end else begin
                exp_rsp = rsp_due.pop_front();
                if (out_item.status !== exp_rsp.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, exp_rsp.status, out_item.status);
                    fail_count++;
                end
                if (out_item.bit_number !== exp_rsp.bit_number) begin
                    $display("%0t: bit_number expected %0d actual %0d",
                             $realtime, exp_rsp.bit_number, out_item.bit_number);
                    fail_count++;
                end
                if (out_item.word_data !== exp_rsp.word_data) begin
                    $display("%0t: word_data expected %h actual %h",
                             $realtime, exp_rsp.word_data, out_item.word_data);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_directed();
        set_map_bits(BITS_IN_USE_RST);
        send_req(make_req(REQ_READ_WORD, 0, 0, '0));
        send_req(make_req(REQ_READ_WORD, MAP_WORDS - 1, 2 ** BIT_W - 1, '1));
        send_req(make_req(REQ_ALLOC_BIT, 0, 0, '0));
        send_req(make_req(REQ_ALLOC_BYTE, 0, 0, '0));
        send_req(make_req(REQ_FREE_BIT, 0, 0, '0));
        send_req(make_req(REQ_FREE_BIT, 0, 0, '0));
        send_req(make_req(REQ_FREE_BIT, 0, 2 ** BIT_W - 1, '0));
        send_req(make_req(REQ_WRITE_WORD, MAP_WORDS - 1, 0, '1));
        send_req(make_req(REQ_ALLOC_BIT, MAP_WORDS - 1, 0, '0));
        send_req(make_req(REQ_WRITE_WORD, MAP_WORDS - 1, 0, 32'h7FFF_FFFF));
        send_req(make_req(REQ_ALLOC_BIT, MAP_WORDS - 1, 0, '0));
        send_req(make_req(REQ_FREE_BIT, 0, 2 ** BIT_W - 1, '0));
        send_req(make_req(REQ_READ_WORD, MAP_WORDS - 1, 0, '0));
        send_req(make_req(REQ_WRITE_WORD, 512, 2 ** BIT_W - 1, 32'hAAAA_AAAA));
        send_req(make_req(REQ_READ_WORD, 512, 0, '0));
        send_req(make_req(REQ_WRITE_WORD, 511, 0, 32'h5555_5555));
        send_req(make_req(REQ_READ_WORD, 511, 0, '0));
        send_req(make_req(REQ_WRITE_WORD, 0, 0, '0));
        for (int c = REQ_READ_WORD + 1; c <= REQ_CODE_MAX; c++) begin
            send_req(make_req(REQ_W'(c), MAP_WORDS - 1, 2 ** BIT_W - 1, '1));
        end
        send_req(make_req(REQ_ALLOC_BIT, 0, 0, '0));
    endtask

    task automatic test_scan_limits();
        set_map_bits('0);
        send_req(make_req(REQ_ALLOC_BIT, 0, 0, '0));
        send_req(make_req(REQ_ALLOC_BYTE, 0, 0, '0));
        set_map_bits(CFG_W'(40));
        send_req(make_req(REQ_WRITE_WORD, 0, 0, '0));
        send_req(make_req(REQ_WRITE_WORD, 1, 0, '0));
        repeat (6) send_req(make_req(REQ_ALLOC_BYTE, 0, 0, '0));
        send_req(make_req(REQ_ALLOC_BIT, 2, 0, '0));
        send_req(make_req(REQ_ALLOC_BIT, 1, 0, '0));
        set_map_bits('1);
        send_req(make_req(REQ_ALLOC_BIT, MAP_WORDS - 1, 0, '0));
        send_req(make_req(REQ_ALLOC_BYTE, 0, 0, '0));
        send_req(make_req(REQ_FREE_BIT, 0, 2 ** BIT_W - 1, '0));
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] bits;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: bits = BITS_IN_USE_RST;
                1: bits = '1;
                default: begin
                    case ($urandom_range(0, 3))
                        0: bits = CFG_W'($urandom_range(1, 255));
                        1: bits = CFG_W'($urandom_range(256, 2048));
                        2: bits = CFG_W'($urandom);
                        default: bits = CFG_W'($urandom_range(8, 64));
                    endcase
                end
            endcase
            set_map_bits(bits);
            no_gaps = (ph % 3 == 2);
            for (int n = 0; n < PHASE_REQS; n++) begin
                send_req(random_req());
            end
            no_gaps = 1'b0;
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_scan_limits();
        test_random_traffic();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
